>>> sv/text_console_engine_assert.svh
// assertion macros for the text console engine rtl
// no dependencies; included by text_console_engine.sv, which carries the assertions
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console engine check failed");

// next-cycle implication, disabled while reset is low
`define TCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console engine check failed");

`endif

>>> sv/tce_pkg.sv
// shared types and constants of the text console engine
// no dependencies; used by tce_addr and text_console_engine
package tce_pkg;

    localparam int IDX_W = 16;

    localparam logic [7:0] CURSOR_ATTR = 8'hf0;
    localparam logic [7:0] BLANK_ATTR  = 8'h1f;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_BS       = 8'h08;

    localparam logic [7:0] COLS_RESET  = 8'd80;
    localparam logic [6:0] LINES_RESET = 7'd25;

    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_GOTO  = 3'd1;
    localparam logic [2:0] MODE_WCELL = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [0:0] CFG_COLUMNS = 1'b0;
    localparam logic [0:0] CFG_LINES   = 1'b1;

    // effective geometry after clamping to the store size
    typedef struct packed {
        logic [7:0]       cols;
        logic [6:0]       rows;
        logic [IDX_W-1:0] area;
    } t_geom;

    // cell index and in-screen flag
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             ok;
    } t_addr;

endpackage

>>> sv/tce_addr.sv
// cell address unit: clamped geometry, registered row product and area
// depends on tce_pkg
module tce_addr #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  logic               i_clk,
    input  logic [7:0]         i_columns,
    input  logic [6:0]         i_lines,
    input  logic [7:0]         i_ax,
    input  logic [7:0]         i_ay,
    output tce_pkg::t_geom     o_geom,
    output tce_pkg::t_addr     o_addr
);

    localparam int IW = tce_pkg::IDX_W;

    logic [7:0]    cols;
    logic [6:0]    rows;
    logic [IW-1:0] r_area;
    logic [IW-1:0] r_prod;
    logic [IW-1:0] idx;

    assign cols = ({1'b0, i_columns} > 9'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : i_columns;
    assign rows = ({2'b0, i_lines} > 9'(MAX_LINES)) ? 7'(MAX_LINES) : i_lines;

    always_ff @(posedge i_clk) begin
        r_area <= {8'b0, cols} * {9'b0, rows};
        r_prod <= {8'b0, i_ay} * {8'b0, cols};
    end

    assign idx = {8'b0, i_ax} + r_prod;

    assign o_geom.cols = cols;
    assign o_geom.rows = rows;
    assign o_geom.area = r_area;
    assign o_addr.idx  = idx;
    assign o_addr.ok   = idx < r_area;

endmodule

>>> sv/text_console_engine.sv
// text console engine top level: sequencer, cell store and register port
// depends on tce_pkg, tce_addr and text_console_engine_assert.svh
`include "text_console_engine_assert.svh"

// Text console over a store of MAX_COLUMNS*MAX_LINES character/attribute
// cells (char in bits 7:0, attribute in 15:8), kept in one synchronous RAM
// with one write port (per-byte enables) and one registered read port.
// A command is taken when start is high and busy is low; its one result
// word shows on the o_ ports for exactly one cycle with o_done high, in the
// cycle that follows the last busy cycle. The receiver cannot stall, so the
// result must be sampled then. Accesses by cell coordinate run through one
// address unit (registered row*columns product, then add and compare); the
// reset sweep, scroll copy and blank fill address the store directly. Put
// character, go to, carriage return, line feed, backspace, clear and write
// cell hide and then show the cursor overlay with memory round trips;
// write cell skips both when the cell is off screen. A printable put
// character that scrolls first copies keep cells up and blanks the rest of
// the area, where area = columns*lines in use and keep is the number of
// cells moved up; clear blanks the whole area. Read cell takes one read,
// and unused codes and ignored characters go straight to the result word.
// After reset the block sweeps the whole store once to blank it, which
// holds busy high until the sweep ends; register writes are taken
// throughout. Registers (index 0 columns, 1 lines) may be written only
// while the block is idle and take effect with the next command.
module text_console_engine #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_ch,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_attr,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_done,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    output logic [7:0] o_cursor_x,
    output logic [7:0] o_cursor_y
);

    localparam int STORE = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = $clog2(STORE);
    localparam int IW    = tce_pkg::IDX_W;
    localparam logic [IW-1:0] STORE_LAST = IW'(STORE - 1);

    // sequencer states
    localparam logic [4:0] S_INIT  = 5'd0;   // reset sweep of the store
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_H_M   = 5'd2;   // hide cursor: product
    localparam logic [4:0] S_H_R   = 5'd3;   // hide cursor: restore attr
    localparam logic [4:0] S_S_M   = 5'd4;   // show cursor: product
    localparam logic [4:0] S_S_R   = 5'd5;   // show cursor: read + overlay
    localparam logic [4:0] S_RD_M  = 5'd6;
    localparam logic [4:0] S_RD_R  = 5'd7;
    localparam logic [4:0] S_WC_M  = 5'd8;
    localparam logic [4:0] S_WC_R  = 5'd9;
    localparam logic [4:0] S_WC_W  = 5'd10;
    localparam logic [4:0] S_P_CHK = 5'd11;  // wrap and scroll decision
    localparam logic [4:0] S_OFF_M = 5'd12;  // scroll offset product
    localparam logic [4:0] S_OFF_R = 5'd13;
    localparam logic [4:0] S_SH_RD = 5'd14;  // scroll copy: read source
    localparam logic [4:0] S_SH_WR = 5'd15;  // scroll copy: write target
    localparam logic [4:0] S_BL    = 5'd16;  // blank fill
    localparam logic [4:0] S_P_M   = 5'd17;
    localparam logic [4:0] S_P_R   = 5'd18;  // put the character byte
    localparam logic [4:0] S_DONE  = 5'd19;

    // command kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_MOVE  = 3'd1;
    localparam logic [2:0] K_WCELL = 3'd2;
    localparam logic [2:0] K_CLEAR = 3'd3;
    localparam logic [2:0] K_PUT   = 3'd4;
    localparam logic [2:0] K_READ  = 3'd5;

    logic [4:0]    r_state;
    logic [2:0]    r_kind;
    logic [IW-1:0] r_ptr;
    logic [7:0]    r_col;
    logic [7:0]    r_row;
    logic [7:0]    r_saved;
    logic [7:0]    r_columns;
    logic [6:0]    r_lines;
    logic [7:0]    r_tx;
    logic [7:0]    r_ty;
    logic [7:0]    r_ax;
    logic [7:0]    r_ay;
    logic [7:0]    r_ch;
    logic [7:0]    r_attr;
    logic [IW-1:0] r_widx;
    logic [IW-1:0] r_off;
    logic [IW-1:0] r_keep;
    logic          r_rd_ok;
    logic          r_cap;
    logic [15:0]   r_rdata;
    logic          r_done;
    logic [7:0]    r_out_char;
    logic [7:0]    r_out_attr;

    logic [15:0]   r_cells [STORE];

    tce_pkg::t_geom geom;
    tce_pkg::t_addr addr;

    // memory port controls
    logic          mem_we_c;
    logic          mem_we_a;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [IW-1:0] sh_src;
    logic [IW-1:0] ptr_inc;
    logic [IW-1:0] area_last;
    logic [7:0]    row_inc;
    logic [7:0]    rows8;
    logic          wrap;
    logic [7:0]    wc;
    logic [7:0]    wr;
    logic [7:0]    scroll_n;
    logic [7:0]    last_row;
    logic [IW-1:0] keep;

    tce_addr #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_addr (
        .i_clk     (i_clk),
        .i_columns (r_columns),
        .i_lines   (r_lines),
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .o_geom    (geom),
        .o_addr    (addr)
    );

    assign busy = (r_state != S_IDLE);

    assign sh_src    = r_ptr + r_off;
    assign ptr_inc   = r_ptr + 1'b1;
    assign area_last = geom.area - 1'b1;
    // cursor rows saturate at the top of the byte
    assign row_inc   = (r_row == 8'hff) ? 8'hff : r_row + 8'd1;
    assign rows8     = {1'b0, geom.rows};
    assign wrap      = (r_col >= geom.cols);
    assign wc        = wrap ? 8'd0 : r_col;
    assign wr        = wrap ? row_inc : r_row;
    assign scroll_n  = wr - rows8 + 8'd1;
    assign last_row  = rows8 - 8'd1;
    // cells that survive the scroll; r_ay holds the line count to scroll
    assign keep      = (r_ay >= rows8) ? '0 : geom.area - addr.idx;

    // register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tce_pkg::COLS_RESET;
            r_lines   <= tce_pkg::LINES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tce_pkg::CFG_COLUMNS: r_columns <= i_cfg_wdata;
                tce_pkg::CFG_LINES:   r_lines   <= i_cfg_wdata[6:0];
                default:              r_lines   <= r_lines;
            endcase
        end
    end

    // memory port selection per state
    always_comb begin
        mem_we_c  = 1'b0;
        mem_we_a  = 1'b0;
        mem_waddr = addr.idx[AW-1:0];
        mem_wdata = {tce_pkg::BLANK_ATTR, tce_pkg::BLANK_CHAR};
        mem_re    = 1'b0;
        mem_raddr = addr.idx[AW-1:0];
        case (r_state)
            S_INIT: begin
                // cell 0 carries the cursor overlay after reset
                mem_we_c  = 1'b1;
                mem_we_a  = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                if (r_ptr == '0) begin
                    mem_wdata = {tce_pkg::CURSOR_ATTR, tce_pkg::BLANK_CHAR};
                end
            end
            S_H_R: begin
                // put back the attribute under the cursor
                mem_we_a  = addr.ok;
                mem_wdata = {r_saved, 8'h00};
            end
            S_S_R: begin
                // read-first: old attribute comes back while overlay goes in
                mem_re    = addr.ok;
                mem_we_a  = addr.ok;
                mem_wdata = {tce_pkg::CURSOR_ATTR, 8'h00};
            end
            S_RD_R: begin
                mem_re = addr.ok;
            end
            S_WC_W: begin
                mem_we_c  = 1'b1;
                mem_we_a  = 1'b1;
                mem_waddr = r_widx[AW-1:0];
                mem_wdata = {r_attr, r_ch};
            end
            S_SH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = sh_src[AW-1:0];
            end
            S_SH_WR: begin
                mem_we_c  = 1'b1;
                mem_we_a  = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = r_rdata;
            end
            S_BL: begin
                mem_we_c  = 1'b1;
                mem_we_a  = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
            end
            S_P_R: begin
                // char byte only; the attr read back becomes the saved attr
                mem_we_c  = 1'b1;
                mem_wdata = {8'h00, r_ch};
                mem_re    = 1'b1;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (mem_we_c) begin
            r_cells[mem_waddr][7:0] <= mem_wdata[7:0];
        end
        if (mem_we_a) begin
            r_cells[mem_waddr][15:8] <= mem_wdata[15:8];
        end
        if (mem_re) begin
            r_rdata <= r_cells[mem_raddr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
            r_saved <= tce_pkg::BLANK_ATTR;
            r_cap   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_cap  <= 1'b0;
            // attribute read under the cursor becomes the saved one
            if (r_cap) begin
                r_saved <= r_rdata[15:8];
            end
            case (r_state)
                S_INIT: begin
                    r_ptr <= ptr_inc;
                    if (r_ptr == STORE_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_ch   <= i_ch;
                        r_attr <= i_attr;
                        r_ax   <= r_col;
                        r_ay   <= r_row;
                        r_kind <= K_NONE;
                        case (i_mode)
                            tce_pkg::MODE_PUT: begin
                                if (i_ch == tce_pkg::CH_CR) begin
                                    r_kind  <= K_MOVE;
                                    r_tx    <= 8'd0;
                                    r_ty    <= r_row;
                                    r_state <= S_H_M;
                                end else if (i_ch == tce_pkg::CH_LF) begin
                                    r_kind  <= K_MOVE;
                                    r_tx    <= 8'd0;
                                    r_ty    <= row_inc;
                                    r_state <= S_H_M;
                                end else if (i_ch == tce_pkg::CH_BS) begin
                                    if (r_col != 8'd0) begin
                                        r_kind  <= K_MOVE;
                                        r_tx    <= r_col - 8'd1;
                                        r_ty    <= r_row;
                                        r_state <= S_H_M;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end else if (geom.cols == 8'd0 || geom.rows == 7'd0) begin
                                    // empty screen: printable bytes are dropped
                                    r_state <= S_DONE;
                                end else begin
                                    r_kind  <= K_PUT;
                                    r_state <= S_H_M;
                                end
                            end
                            tce_pkg::MODE_GOTO: begin
                                r_kind  <= K_MOVE;
                                r_tx    <= i_x;
                                r_ty    <= i_y;
                                r_state <= S_H_M;
                            end
                            tce_pkg::MODE_WCELL: begin
                                r_kind  <= K_WCELL;
                                r_ax    <= i_x;
                                r_ay    <= i_y;
                                r_state <= S_WC_M;
                            end
                            tce_pkg::MODE_CLEAR: begin
                                r_kind  <= K_CLEAR;
                                r_state <= S_H_M;
                            end
                            tce_pkg::MODE_READ: begin
                                r_kind  <= K_READ;
                                r_ax    <= i_x;
                                r_ay    <= i_y;
                                r_state <= S_RD_M;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_M: r_state <= S_RD_R;
                S_RD_R: begin
                    r_rd_ok <= addr.ok;
                    r_state <= S_DONE;
                end
                S_WC_M: r_state <= S_WC_R;
                S_WC_R: begin
                    // off-screen writes leave everything alone
                    if (addr.ok) begin
                        r_widx  <= addr.idx;
                        r_ax    <= r_col;
                        r_ay    <= r_row;
                        r_state <= S_H_M;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WC_W: begin
                    r_ax    <= r_col;
                    r_ay    <= r_row;
                    r_state <= S_S_M;
                end
                S_H_M: r_state <= S_H_R;
                S_H_R: begin
                    case (r_kind)
                        K_MOVE: begin
                            r_col   <= r_tx;
                            r_row   <= r_ty;
                            r_ax    <= r_tx;
                            r_ay    <= r_ty;
                            r_state <= S_S_M;
                        end
                        K_WCELL: r_state <= S_WC_W;
                        K_CLEAR: begin
                            r_ptr <= '0;
                            if (geom.area != '0) begin
                                r_state <= S_BL;
                            end else begin
                                r_col   <= 8'd0;
                                r_row   <= 8'd0;
                                r_ax    <= 8'd0;
                                r_ay    <= 8'd0;
                                r_state <= S_S_M;
                            end
                        end
                        K_PUT:   r_state <= S_P_CHK;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_P_CHK: begin
                    // wrap at the column limit, then scroll if below the screen
                    r_col <= wc;
                    r_row <= wr;
                    if (wr >= rows8) begin
                        r_ax    <= 8'd0;
                        r_ay    <= scroll_n;
                        r_state <= S_OFF_M;
                    end else begin
                        r_ax    <= wc;
                        r_ay    <= wr;
                        r_state <= S_P_M;
                    end
                end
                S_OFF_M: r_state <= S_OFF_R;
                S_OFF_R: begin
                    // with column 0 the address unit yields lines*columns
                    r_off  <= addr.idx;
                    r_keep <= keep;
                    r_ptr  <= '0;
                    if (keep != '0) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_BL;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_ptr <= ptr_inc;
                    if (ptr_inc == r_keep) begin
                        r_state <= S_BL;
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_BL: begin
                    r_ptr <= ptr_inc;
                    if (r_ptr == area_last) begin
                        if (r_kind == K_CLEAR) begin
                            r_col   <= 8'd0;
                            r_row   <= 8'd0;
                            r_ax    <= 8'd0;
                            r_ay    <= 8'd0;
                            r_state <= S_S_M;
                        end else begin
                            r_row   <= last_row;
                            r_ax    <= r_col;
                            r_ay    <= last_row;
                            r_state <= S_P_M;
                        end
                    end
                end
                S_P_M: r_state <= S_P_R;
                S_P_R: begin
                    r_cap   <= 1'b1;
                    r_col   <= r_col + 8'd1;
                    r_ax    <= r_col + 8'd1;
                    r_ay    <= r_row;
                    r_state <= S_S_M;
                end
                S_S_M: r_state <= S_S_R;
                S_S_R: begin
                    r_cap   <= addr.ok;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            if (r_kind == K_READ && r_rd_ok) begin
                r_out_char <= r_rdata[7:0];
                r_out_attr <= r_rdata[15:8];
            end else begin
                r_out_char <= 8'd0;
                r_out_attr <= 8'd0;
            end
        end
    end

    assign o_done      = r_done;
    assign o_cell_char = r_out_char;
    assign o_cell_attr = r_out_attr;
    assign o_cursor_x  = r_col;
    assign o_cursor_y  = r_row;

    `TCE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `TCE_ASSERT_IMP(a_idle_with_word, i_clk, i_rst_n, $fell(busy), o_done || ($past(r_state) == S_INIT))
    `TCE_ASSERT_IMP(a_sweep_in_area, i_clk, i_rst_n, (r_state == S_BL) || (r_state == S_SH_WR), r_ptr < geom.area)
    `TCE_ASSERT_IMP(a_cell_only_on_read, i_clk, i_rst_n, o_done && (r_kind != K_READ), (o_cell_char == 8'd0) && (o_cell_attr == 8'd0))

endmodule

>>> verif/testbench.sv
// self-checking testbench for text_console_engine: shadow screen, result check, stimulus
// depends on tce_pkg and the text_console_engine rtl
`timescale 1ns / 100ps

localparam int unsigned MAX_COLS    = 128;
localparam int unsigned MAX_ROWS    = 64;
localparam int unsigned STORE_CELLS = MAX_COLS * MAX_ROWS;

// one command word as taken by the block
typedef struct packed {
    logic [2:0] mode;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] attr;
} t_console_cmd;

// one result word
typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
} t_console_word;

// shadow copy of the console: cell store, cursor, geometry and the words it owes
class t_console_tracker;
    bit [15:0]     cells [STORE_CELLS];
    int unsigned   cur_col;
    int unsigned   cur_row;
    bit [7:0]      saved;
    int unsigned   columns;
    int unsigned   lines;
    t_console_word owed [$];
    int            errors;
    int            commands;
    int            results;

    function new();
        for (int i = 0; i < STORE_CELLS; i++)
            cells[i] = {tce_pkg::BLANK_ATTR, tce_pkg::BLANK_CHAR};
        columns  = 32'(tce_pkg::COLS_RESET);
        lines    = 32'(tce_pkg::LINES_RESET);
        cur_col  = 0;
        cur_row  = 0;
        saved    = tce_pkg::BLANK_ATTR;
        errors   = 0;
        commands = 0;
        results  = 0;
        draw_cursor();
    endfunction

    function int unsigned used_cols();
        return columns > MAX_COLS ? MAX_COLS : columns;
    endfunction

    function int unsigned used_rows();
        return lines > MAX_ROWS ? MAX_ROWS : lines;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    // row-major index, flag set when it falls in the active area
    function bit locate(int unsigned cx, int unsigned cy, output int unsigned idx);
        int unsigned c;
        c   = used_cols();
        idx = cx + cy * c;
        return idx < c * used_rows() && idx < STORE_CELLS;
    endfunction

    function void draw_cursor();
        int unsigned i;
        if (!locate(cur_col, cur_row, i))
            return;
        saved          = cells[i][15:8];
        cells[i][15:8] = tce_pkg::CURSOR_ATTR;
    endfunction

    function void erase_cursor();
        int unsigned i;
        if (!locate(cur_col, cur_row, i))
            return;
        cells[i][15:8] = saved;
    endfunction

    function void move_to(int unsigned cx, int unsigned cy);
        erase_cursor();
        cur_col = cx & 255;
        cur_row = cy > 255 ? 255 : cy;
        draw_cursor();
    endfunction

    function void scroll_up(int unsigned n, int unsigned c, int unsigned l);
        int unsigned keep;
        keep = n >= l ? 0 : (l - n) * c;
        for (int unsigned i = 0; i < keep; i++)
            cells[i] = cells[i + n * c];
        for (int unsigned i = keep; i < l * c; i++)
            cells[i] = {tce_pkg::BLANK_ATTR, tce_pkg::BLANK_CHAR};
    endfunction

    function void put_glyph(bit [7:0] ch);
        int unsigned c;
        int unsigned l;
        int unsigned i;
        c = used_cols();
        l = used_rows();
        if (ch == tce_pkg::CH_CR) begin
            move_to(0, cur_row);
            return;
        end
        if (ch == tce_pkg::CH_LF) begin
            move_to(0, cur_row + 1);
            return;
        end
        if (ch == tce_pkg::CH_BS) begin
            if (cur_col != 0)
                move_to(cur_col - 1, cur_row);
            return;
        end
        // printable byte on an empty screen is dropped
        if (c == 0 || l == 0)
            return;
        if (cur_col >= c)
            move_to(0, cur_row + 1);
        if (cur_row >= l) begin
            erase_cursor();
            scroll_up(cur_row - l + 1, c, l);
            cur_row = l - 1;
            draw_cursor();
        end
        erase_cursor();
        i = cur_col + cur_row * c;
        cells[i][7:0] = ch;
        draw_cursor();
        move_to(cur_col + 1, cur_row);
    endfunction

    // only the active area is blanked
    function void blank_screen();
        int unsigned n;
        n = used_cols() * used_rows();
        erase_cursor();
        for (int unsigned i = 0; i < n && i < STORE_CELLS; i++)
            cells[i] = {tce_pkg::BLANK_ATTR, tce_pkg::BLANK_CHAR};
        cur_col = 0;
        cur_row = 0;
        draw_cursor();
    endfunction

    function t_console_word apply_command(t_console_cmd cmd);
        t_console_word w;
        int unsigned   i;
        w = '0;
        case (cmd.mode)
            tce_pkg::MODE_PUT:   put_glyph(cmd.ch);
            tce_pkg::MODE_GOTO:  move_to(32'(cmd.x), 32'(cmd.y));
            tce_pkg::MODE_WCELL: begin
                if (locate(32'(cmd.x), 32'(cmd.y), i)) begin
                    erase_cursor();
                    cells[i] = {cmd.attr, cmd.ch};
                    draw_cursor();
                end
            end
            tce_pkg::MODE_CLEAR: blank_screen();
            tce_pkg::MODE_READ: begin
                if (locate(32'(cmd.x), 32'(cmd.y), i)) begin
                    w.cell_char = cells[i][7:0];
                    w.cell_attr = cells[i][15:8];
                end
            end
            default: ;
        endcase
        w.cursor_x = cur_col[7:0];
        w.cursor_y = cur_row[7:0];
        return w;
    endfunction

    function void take_command(t_console_cmd cmd);
        owed.push_back(apply_command(cmd));
        commands++;
    endfunction

    function void write_reg(logic [0:0] idx, logic [7:0] data);
        if (idx == tce_pkg::CFG_COLUMNS)
            columns = 32'(data);
        else
            lines = 32'(data[6:0]);
    endfunction

    task flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got_v, want_v);
        errors++;
    endtask

    task match_result(t_console_word got);
        t_console_word want;
        results++;
        if (owed.size() == 0) begin
            flag_mismatch("result word with nothing owed", got, 0);
            return;
        end
        want = owed.pop_front();
        if (got.cell_char !== want.cell_char)
            flag_mismatch("cell_char", 32'(got.cell_char), 32'(want.cell_char));
        if (got.cell_attr !== want.cell_attr)
            flag_mismatch("cell_attr", 32'(got.cell_attr), 32'(want.cell_attr));
        if (got.cursor_x !== want.cursor_x)
            flag_mismatch("cursor_x", 32'(got.cursor_x), 32'(want.cursor_x));
        if (got.cursor_y !== want.cursor_y)
            flag_mismatch("cursor_y", 32'(got.cursor_y), 32'(want.cursor_y));
    endtask
endclass

module testbench;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 10;
    localparam int          RANDOM_ITEMS   = 800;
    // slowest legal command is a full-store scroll
    localparam int          WATCHDOG_LIMIT = 100000;
    localparam int          TAIL_CYCLES    = 50;
    localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic [2:0] i_mode      = '0;
    logic [7:0] i_ch        = '0;
    logic [7:0] i_x         = '0;
    logic [7:0] i_y         = '0;
    logic [7:0] i_attr      = '0;
    logic       i_cfg_we    = 1'b0;
    logic [0:0] i_cfg_idx   = '0;
    logic [7:0] i_cfg_wdata = '0;
    logic       busy;
    logic       o_done;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_attr;
    logic [7:0] o_cursor_x;
    logic [7:0] o_cursor_y;

    t_console_tracker screen;
    t_console_word    seen;
    int               quiet_cycles = 0;
    int               burst_left   = 0;
    int               gap_max      = 0;
    int               settings     = 0;
    int               random_sent  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    text_console_engine #(
        .MAX_COLUMNS (MAX_COLS),
        .MAX_LINES   (MAX_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_ch        (i_ch),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_attr      (i_attr),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_cell_char (o_cell_char),
        .o_cell_attr (o_cell_attr),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y)
    );

    // monitor: sample at the rising edge; the result word is checked before a
    // command taken at the same edge is noted, since it belongs to an older one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen = {o_cell_char, o_cell_attr, o_cursor_x, o_cursor_y};
                screen.match_result(seen);
            end
            if (start && !busy)
                screen.take_command({i_mode, i_ch, i_x, i_y, i_attr});
            // watchdog on cycles where no word moves either way
            if (o_done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // present one command from a falling edge and hold it until taken;
    // start stays high on return so a burst runs back to back
    task automatic send_command(input logic [2:0] mode, input logic [7:0] ch,
                                input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] attr);
        start  = 1'b1;
        i_mode = mode;
        i_ch   = ch;
        i_x    = x;
        i_y    = y;
        i_attr = attr;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender bursts: random length, random gap in front of each one
    task automatic pace();
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // idle: nothing owed and the block not busy
    task automatic settle();
        start = 1'b0;
        while (busy || screen.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [7:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        screen.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 8'($urandom_range(0, 255));
    endtask

    // coordinate mostly inside the active span, sometimes anywhere
    function automatic logic [7:0] pick_coord(int unsigned span);
        if (span == 0 || $urandom_range(0, 99) < 15)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, span - 1));
    endfunction

    // mostly printing and cell traffic, a few clears and spare codes
    task automatic random_command();
        int unsigned r;
        logic [2:0]  mode;
        logic [7:0]  ch;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  attr;
        r    = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        attr = 8'($urandom_range(0, 255));
        x    = pick_coord(screen.used_cols());
        y    = pick_coord(screen.used_rows());
        if (r < 45) begin
            mode = tce_pkg::MODE_PUT;
            case ($urandom_range(0, 9))
                0: ch = tce_pkg::CH_CR;
                1: ch = tce_pkg::CH_LF;
                2: ch = tce_pkg::CH_BS;
                default: ;
            endcase
        end else if (r < 58) begin
            mode = tce_pkg::MODE_GOTO;
        end else if (r < 72) begin
            mode = tce_pkg::MODE_WCELL;
        end else if (r < 88) begin
            mode = tce_pkg::MODE_READ;
        end else if (r < 93) begin
            mode = tce_pkg::MODE_CLEAR;
        end else begin
            mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        pace();
        send_command(mode, ch, x, y, attr);
    endtask

    initial begin
        int unsigned cval;
        int unsigned lval;
        int          phase;
        int          count;

        screen = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        // wait out the store-clearing sweep after reset
        settle();

        // directed pass at the reset geometry (80 x 25)
        send_command(tce_pkg::MODE_READ,  8'h00, 8'd0,   8'd0,   8'h00);
        send_command(tce_pkg::MODE_PUT,   8'h41, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_PUT,   tce_pkg::CH_BS, 8'h00,  8'h00,  8'h00);
        // backspace at column zero stays put
        send_command(tce_pkg::MODE_PUT,   tce_pkg::CH_BS, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_PUT,   tce_pkg::CH_LF, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_PUT,   tce_pkg::CH_CR, 8'h00,  8'h00,  8'h00);
        // cursor off screen, then line feed saturates the row
        send_command(tce_pkg::MODE_GOTO,  8'h00, 8'd255, 8'd255, 8'h00);
        send_command(tce_pkg::MODE_PUT,   tce_pkg::CH_LF, 8'h00,  8'h00,  8'h00);
        // printable at row 255 scrolls the whole screen away
        send_command(tce_pkg::MODE_PUT,   8'h5a, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_GOTO,  8'h00, 8'd79,  8'd24,  8'h00);
        send_command(tce_pkg::MODE_PUT,   8'h00, 8'h00,  8'h00,  8'h00);
        // wrap at the column limit on the bottom row, one-line scroll
        send_command(tce_pkg::MODE_PUT,   8'hff, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_WCELL, 8'hff, 8'd79,  8'd23,  8'h00);
        // write outside the screen leaves cursor and cells alone
        send_command(tce_pkg::MODE_WCELL, 8'h55, 8'd255, 8'd255, 8'hff);
        // write onto the cursor cell, then read back the overlay
        send_command(tce_pkg::MODE_WCELL, 8'h7e, 8'd1,   8'd24,  8'ha5);
        send_command(tce_pkg::MODE_READ,  8'h00, 8'd1,   8'd24,  8'h00);
        send_command(tce_pkg::MODE_READ,  8'h00, 8'd80,  8'd0,   8'h00);
        send_command(tce_pkg::MODE_READ,  8'h00, 8'd255, 8'd255, 8'h00);
        send_command(tce_pkg::MODE_GOTO,  8'h00, 8'd255, 8'd0,   8'h00);
        send_command(tce_pkg::MODE_GOTO,  8'h00, 8'd0,   8'd255, 8'h00);
        send_command(tce_pkg::MODE_PUT,   8'h71, 8'h00,  8'h00,  8'h00);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_command(3'(m), 8'hff, 8'hff, 8'hff, 8'hff);
        send_command(tce_pkg::MODE_CLEAR, 8'h00, 8'h00,  8'h00,  8'h00);
        send_command(tce_pkg::MODE_READ,  8'h00, 8'd0,   8'd0,   8'h00);

        // random phases, each under its own geometry
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin cval = 1;   lval = 1;   end
                1: begin cval = 128; lval = 64;  end
                2: begin cval = 0;   lval = 7;   end  // no columns: empty screen
                3: begin cval = 9;   lval = 0;   end  // no lines: empty screen
                4: begin cval = 200; lval = 100; end  // both clamp to the store size
                5: begin cval = 128; lval = 1;   end
                6: begin cval = 1;   lval = 64;  end
                7: begin cval = 80;  lval = 25;  end
                default: begin
                    cval = $urandom_range(1, 16);
                    lval = $urandom_range(1, 8);
                end
            endcase
            settle();
            set_reg(tce_pkg::CFG_COLUMNS, 8'(cval));
            // bit 7 of the lines word is not stored; toggle it anyway
            set_reg(tce_pkg::CFG_LINES, 8'(lval & 127) | 8'($urandom_range(0, 1) << 7));
            settings++;

            // every third phase runs with no gaps at all
            gap_max    = (phase % 3 == 0) ? 0 : $urandom_range(1, 25);
            burst_left = 0;
            if (screen.used_cols() * screen.used_rows() > 1024)
                count = 12;
            else if (screen.used_cols() * screen.used_rows() == 0)
                count = 40;
            else
                count = 60;
            repeat (count) begin
                random_command();
                random_sent++;
            end
            phase++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d commands over %0d register settings, %0d result words checked",
                 screen.commands, settings, screen.results);
        $display("%0d mismatches", screen.errors);
        if (screen.errors == 0 && screen.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
